// ----- design/wss_pkg.sv -----
// ----------------------------------------------------------------------------
// wss_pkg
// Shared types and constants of the wildcard signature scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

  // signature and offset sizing
  localparam int MAX_PATTERN   = 40;
  localparam int OFFSET_BITS   = 32;
  localparam int WIN_DEPTH     = MAX_PATTERN - 1;
  localparam int LEN_BITS      = 6;
  localparam int PAT_WORDS     = 5;
  localparam int PAT_BITS      = 64 * PAT_WORDS;
  localparam int CARE_BITS     = 40;
  localparam int ADDR_BITS     = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_0 = 3'd0,
    CFG_PATTERN_1 = 3'd1,
    CFG_PATTERN_2 = 3'd2,
    CFG_PATTERN_3 = 3'd3,
    CFG_PATTERN_4 = 3'd4,
    CFG_CARE_MASK = 3'd5,
    CFG_LENGTH    = 3'd6,
    CFG_BASE      = 3'd7
  } cfg_idx_t;

  // match outcome, also used as the saturating match count
  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_UNIQUE = 2'd1,
    ST_AMBIG  = 2'd2
  } status_t;

  // input request
  typedef struct packed {
    logic [7:0] image_byte;
    logic       last_byte;
  } in_item_t;

  // result request
  typedef struct packed {
    logic [1:0]           match_status;
    logic [ADDR_BITS-1:0] match_address;
  } out_item_t;

  // compare stage handed to the tally stage
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic                   hit;
    logic [OFFSET_BITS-1:0] cand_off;
  } scan_stage_t;

  // aligned signature seen by the window cells
  typedef struct packed {
    logic [MAX_PATTERN*8-1:0] sig;
    logic [MAX_PATTERN-1:0]   care;
    logic                     len_ok;
    logic [LEN_BITS-1:0]      len;
  } align_t;

endpackage

`default_nettype wire

// ----- design/wss_cell.sv -----
// ----------------------------------------------------------------------------
// wss_cell
// One window byte: shifts to its neighbor and compares against its signature
// byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_cell
  import wss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       shift_en,
  input  wire logic       clear,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] sig_byte,
  input  wire logic       care,
  output logic      [7:0] byte_out,
  output logic            ok
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  // shift in the younger byte, wipe at end of image
  always_comb begin
    byte_nxt = byte_r;
    if (shift_en) begin
      byte_nxt = clear ? 8'd0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign byte_out = byte_r;

  // wildcard positions always agree
  assign ok = !care || (byte_r == sig_byte);

endmodule

`default_nettype wire

// ----- design/wss_regs.sv -----
// ----------------------------------------------------------------------------
// wss_regs
// Configuration registers and the signature aligned to window distance.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_regs
  import wss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output align_t                        align,
  output logic      [ADDR_BITS-1:0]     image_base
);

  logic [63:0]          pat_r [PAT_WORDS];
  logic [63:0]          pat_nxt [PAT_WORDS];
  logic [CARE_BITS-1:0] care_r, care_nxt;
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;

  logic [PAT_BITS-1:0]      pat_flat;
  logic [MAX_PATTERN*8-1:0] sig_rev;
  logic [MAX_PATTERN-1:0]   care_rev;
  logic [LEN_BITS-1:0]      shamt;

  // register write decode
  always_comb begin
    pat_nxt  = pat_r;
    care_nxt = care_r;
    len_nxt  = len_r;
    base_nxt = base_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_0: pat_nxt[0] = cfg_wdata;
        CFG_PATTERN_1: pat_nxt[1] = cfg_wdata;
        CFG_PATTERN_2: pat_nxt[2] = cfg_wdata;
        CFG_PATTERN_3: pat_nxt[3] = cfg_wdata;
        CFG_PATTERN_4: pat_nxt[4] = cfg_wdata;
        CFG_CARE_MASK: care_nxt   = cfg_wdata[CARE_BITS-1:0];
        CFG_LENGTH:    len_nxt    = cfg_wdata[LEN_BITS-1:0];
        CFG_BASE:      base_nxt   = cfg_wdata;
        default:       base_nxt   = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_r[w] <= 64'd0;
      end
      care_r <= '0;
      len_r  <= '0;
      base_r <= '0;
    end else begin
      pat_r  <= pat_nxt;
      care_r <= care_nxt;
      len_r  <= len_nxt;
      base_r <= base_nxt;
    end
  end

  // reverse the signature so that distance d lines up with byte len-1-d
  always_comb begin
    for (int w = 0; w < PAT_WORDS; w++) begin
      pat_flat[w*64 +: 64] = pat_r[w];
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sig_rev[i*8 +: 8] = pat_flat[(MAX_PATTERN-1-i)*8 +: 8];
      care_rev[i]       = care_r[MAX_PATTERN-1-i];
    end
  end

  assign align.len_ok = (len_r != '0) && (len_r <= LEN_BITS'(MAX_PATTERN));
  assign shamt        = LEN_BITS'(MAX_PATTERN) - len_r;
  assign align.sig    = sig_rev >> {shamt, 3'b000};
  assign align.care   = care_rev >> shamt;
  assign align.len    = len_r;
  assign image_base   = base_r;

endmodule

`default_nettype wire

// ----- design/wss_tally.sv -----
// ----------------------------------------------------------------------------
// wss_tally
// Match count, first offset and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_tally
  import wss_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  scan_stage_t               stage,
  input  wire logic [ADDR_BITS-1:0] image_base,
  output logic                      advance,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_payload
);

  status_t                tally_r, tally_nxt, tally_upd;
  logic [OFFSET_BITS-1:0] first_r, first_nxt, off_sel;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;
  logic                   out_free;

  assign out_free = !out_valid_r || !out_stall;
  // only the image's last request needs the output register
  assign advance  = stage.valid && (!stage.last || out_free);

  // saturating count
  always_comb begin
    tally_upd = tally_r;
    if (stage.hit) begin
      case (tally_r)
        ST_NONE:   tally_upd = ST_UNIQUE;
        ST_UNIQUE: tally_upd = ST_AMBIG;
        default:   tally_upd = ST_AMBIG;
      endcase
    end
  end

  assign off_sel = (tally_r == ST_NONE && stage.hit) ? stage.cand_off : first_r;

  // scan state and result
  always_comb begin
    tally_nxt     = tally_r;
    first_nxt     = first_r;
    out_nxt       = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    if (advance) begin
      tally_nxt = tally_upd;
      first_nxt = off_sel;
      if (stage.last) begin
        tally_nxt             = ST_NONE;
        first_nxt             = '0;
        out_valid_nxt         = 1'b1;
        out_nxt.match_status  = tally_upd;
        out_nxt.match_address = (tally_upd == ST_UNIQUE) ?
                                image_base + ADDR_BITS'(off_sel) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= ST_NONE;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tally_r     <= tally_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

// ----- design/wildcard_signature_scanner_core.sv -----
// ----------------------------------------------------------------------------
// wildcard_signature_scanner_core
// Streams image bytes through a row of window cells and reports whether a
// wildcard signature occurs none, once (with its address) or more times.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall  image_byte, last_byte
//  out_      output     out_valid/out_stall match_status, match_address
//  cfg_      input      cfg_wr_en          cfg_index, cfg_wdata
//
//  one byte per cycle while in_stall is low: the cell row compares every window
//  position at once and shifts on each accepted request; the result of a last
//  byte is registered in the compare stage, then in the tally and output
//  register. rst_n is synchronous and clears all scan state; no clearing
//  pass. in_stall rises only while a last byte waits behind a stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_signature_scanner_core
  import wss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  in_item_t                      in_payload,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_payload,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  align_t                 align;
  logic [ADDR_BITS-1:0]   image_base;
  logic                   accept;
  logic                   advance;
  logic [7:0]             win [WIN_DEPTH];
  logic [MAX_PATTERN-1:0] ok;
  logic                   hit;
  logic [OFFSET_BITS-1:0] cnt_r, cnt_nxt, n_inc;
  scan_stage_t            stage_r, stage_nxt;

  wss_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .align      (align),
    .image_base (image_base)
  );

  assign in_stall = stage_r.valid && !advance;
  assign accept   = in_valid && !in_stall;

  // current byte is distance zero
  assign ok[0] = !align.care[0] || (in_payload.image_byte == align.sig[7:0]);

  // window cell row, cell d holds the byte d+1 requests back
  for (genvar d = 0; d < WIN_DEPTH; d++) begin : g_cell
    logic [7:0] byte_in;
    if (d == 0) begin : g_head
      assign byte_in = in_payload.image_byte;
    end else begin : g_body
      assign byte_in = win[d-1];
    end
    wss_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .clear    (in_payload.last_byte),
      .byte_in  (byte_in),
      .sig_byte (align.sig[(d+1)*8 +: 8]),
      .care     (align.care[d+1]),
      .byte_out (win[d]),
      .ok       (ok[d+1])
    );
  end

  // saturating byte count
  assign n_inc = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign hit   = align.len_ok && (n_inc >= OFFSET_BITS'(align.len)) && (&ok);

  always_comb begin
    cnt_nxt   = cnt_r;
    stage_nxt = stage_r;
    if (advance) begin
      stage_nxt.valid = 1'b0;
    end
    if (accept) begin
      cnt_nxt            = in_payload.last_byte ? '0 : n_inc;
      stage_nxt.valid    = 1'b1;
      stage_nxt.last     = in_payload.last_byte;
      stage_nxt.hit      = hit;
      stage_nxt.cand_off = n_inc - OFFSET_BITS'(align.len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      stage_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      stage_r <= stage_nxt;
    end
  end

  wss_tally u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage       (stage_r),
    .image_base  (image_base),
    .advance     (advance),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// ----- tb/sv/signature_match_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signature_match_checker
// Watches the byte and outcome channels of the scanner, keeps its own scan
// state, predicts the outcome of every image and compares it field by field.
// ----------------------------------------------------------------------------

module signature_match_checker
  import wss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  in_item_t                 in_payload,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  out_item_t                out_payload,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       fail_count,
  output int                       pending_results
);

  // shadow registers
  logic [PAT_BITS-1:0]    sig_bytes;
  logic [CARE_BITS-1:0]   care_bits;
  logic [LEN_BITS-1:0]    sig_len;
  logic [ADDR_BITS-1:0]   image_base;

  // scan state
  logic [7:0]             recent_bytes [WIN_DEPTH];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] first_offset;
  logic [1:0]             match_count;

  out_item_t              expected_outcomes [$];
  out_item_t              oldest;

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic clear_scan();
    for (int k = 0; k < WIN_DEPTH; k++) recent_bytes[k] = 8'h00;
    bytes_seen   = '0;
    first_offset = '0;
    match_count  = ST_NONE;
  endtask

  // full window ending at cur against the signature, wildcards skipped
  function automatic logic window_hit(input logic [7:0] cur);
    int         len;
    int         d;
    logic [7:0] b;
    len = int'(sig_len);
    for (int j = 0; j < len; j++) begin
      d = len - 1 - j;
      if (care_bits[j]) begin
        b = (d == 0) ? cur : recent_bytes[d-1];
        if (b != sig_bytes[8*j +: 8]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // one image byte through the predicted scan
  task automatic scan_byte(input in_item_t req);
    logic [OFFSET_BITS-1:0] n;
    out_item_t              res;
    n = bytes_seen;
    if (n != '1) n++;
    if (sig_len >= 1 && sig_len <= MAX_PATTERN && n >= sig_len &&
        window_hit(req.image_byte)) begin
      if (match_count == ST_NONE) first_offset = n - sig_len;
      if (match_count != ST_AMBIG) match_count++;
    end
    bytes_seen = n;
    for (int k = WIN_DEPTH - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k-1];
    recent_bytes[0] = req.image_byte;
    if (req.last_byte) begin
      res.match_status  = match_count;
      res.match_address = (match_count == ST_UNIQUE) ? image_base + first_offset : '0;
      expected_outcomes = {expected_outcomes, res};
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sig_bytes  = '0;
      care_bits  = '0;
      sig_len    = '0;
      image_base = '0;
      clear_scan();
      expected_outcomes.delete();
    end else begin
      // byte accepted on this edge still sees the old registers
      if (in_valid && !in_stall) scan_byte(in_payload);

      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index)) inside
          CFG_PATTERN_0, CFG_PATTERN_1, CFG_PATTERN_2, CFG_PATTERN_3, CFG_PATTERN_4:
            sig_bytes[64*cfg_index +: 64] = cfg_wdata;
          CFG_CARE_MASK: care_bits  = cfg_wdata[CARE_BITS-1:0];
          CFG_LENGTH:    sig_len    = cfg_wdata[LEN_BITS-1:0];
          CFG_BASE:      image_base = cfg_wdata;
          default: ;
        endcase
      end

      // outcome against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_outcomes.size() == 0) begin
          $error("outcome with no request pending: match_status %0d, match_address %h",
                 out_payload.match_status, out_payload.match_address);
          fail_count++;
        end else begin
          oldest = expected_outcomes.pop_front();
          if (out_payload.match_status !== oldest.match_status) begin
            $error("match_status mismatch: expected %0d, got %0d",
                   oldest.match_status, out_payload.match_status);
            fail_count++;
          end
          if (out_payload.match_address !== oldest.match_address) begin
            $error("match_address mismatch: expected %h, got %h",
                   oldest.match_address, out_payload.match_address);
            fail_count++;
          end
        end
      end
    end
    pending_results <= expected_outcomes.size();
  end

endmodule

// ----- tb/sv/wildcard_signature_scanner_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_signature_scanner_core_test
// Loads signatures, streams images with planted, broken and random matches
// under random sender gaps and receiver stalls, and reports the verdict.
// ----------------------------------------------------------------------------

module wildcard_signature_scanner_core_test;
  import wss_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_BYTES   = 1950;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [7:0] image_q_t [$];

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  in_item_t                 in_payload = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  out_item_t                out_payload;
  logic                     cfg_wr_en  = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata  = '0;

  int fail_count;
  int pending_results;

  // sender and receiver pacing
  bit idle_gaps   = 1'b0;
  int stall_pct   = 0;
  int burst_left  = 0;
  int stall_hold  = 0;
  int sent_bytes  = 0;
  int idle_cycles = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  wildcard_signature_scanner_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  signature_match_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_payload     (out_payload),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // receiver stall in runs of random length
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_hold <= $urandom_range(1, 6);
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_hold <= stall_hold - 1;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // drop valid, wait for every outcome, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic load_signature(input logic [PAT_BITS-1:0] sig,
                                input logic [CARE_BITS-1:0] care,
                                input logic [LEN_BITS-1:0] len,
                                input logic [ADDR_BITS-1:0] base);
    wait_drained();
    write_reg(CFG_PATTERN_0, sig[0   +: 64]);
    write_reg(CFG_PATTERN_1, sig[64  +: 64]);
    write_reg(CFG_PATTERN_2, sig[128 +: 64]);
    write_reg(CFG_PATTERN_3, sig[192 +: 64]);
    write_reg(CFG_PATTERN_4, sig[256 +: 64]);
    write_reg(CFG_CARE_MASK, CFG_DATA_BITS'(care));
    write_reg(CFG_LENGTH, CFG_DATA_BITS'(len));
    write_reg(CFG_BASE, base);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one byte request, with a random gap ahead of each burst
  task automatic send_req(input logic [7:0] b, input logic last);
    if (idle_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_payload <= '{image_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic send_image(input image_q_t img);
    for (int i = 0; i < img.size(); i++) send_req(img[i], i == img.size() - 1);
  endtask

  initial begin
    logic [PAT_BITS-1:0]  sig;
    logic [CARE_BITS-1:0] care;
    logic [LEN_BITS-1:0]  len;
    logic [ADDR_BITS-1:0] base;
    image_q_t             img;
    int                   eff_len;
    int                   img_len;
    int                   pos;
    int                   phase_start;
    int                   phase_goal;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    idle_gaps = 1'b1;
    stall_pct = 25;

    // zero length after reset: nothing matches
    img = '{8'h00, 8'hFF};
    send_image(img);

    // AA 55 then a wildcard; base near the top so the address wraps
    load_signature(320'hC355AA, 40'h3, 6'd3, 64'hFFFF_FFFF_FFFF_FFFE);
    img = '{8'h11, 8'h22, 8'hAA, 8'h55, 8'h00};
    send_image(img);
    // image shorter than the signature
    img = '{8'hAA, 8'h55};
    send_image(img);
    // three matches: ambiguous, tally stays saturated
    img = '{8'hAA, 8'h55, 8'h01, 8'hAA, 8'h55, 8'h02, 8'hAA, 8'h55, 8'hFF};
    send_image(img);

    // length above the maximum behaves like zero length
    load_signature(320'hC355AA, '1, 6'd41, '0);
    img = '{8'hAA, 8'h55, 8'hC3};
    send_image(img);

    // all wildcards: every full window matches
    load_signature('1, '0, 6'd2, 64'h0123_4567_89AB_CDEF);
    img = '{8'h00, 8'hFF};
    send_image(img);
    img = '{8'h5A};
    send_image(img);

    // random phases, each with its own signature and pacing
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0:       len = LEN_BITS'(MAX_PATTERN);
        1:       len = 6'd1;
        2:       len = $urandom_range(0, 1) ? '0 :
                       LEN_BITS'($urandom_range(MAX_PATTERN + 1, 63));
        default: len = LEN_BITS'($urandom_range(2, MAX_PATTERN));
      endcase
      case ($urandom_range(0, 5))
        0:       care = '1;
        1:       care = '0;
        default: care = CARE_BITS'({$urandom(), $urandom()});
      endcase
      if ($urandom_range(0, 7) == 0) begin
        sig = '1;
      end else begin
        for (int k = 0; k < MAX_PATTERN; k++) sig[8*k +: 8] = pick_byte();
      end
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = '1;
        default: base = {$urandom(), $urandom()};
      endcase
      load_signature(sig, care, len, base);

      case ($urandom_range(0, 3))
        0: begin
          idle_gaps = 1'b0;
          stall_pct = 0;
        end
        1: begin
          idle_gaps = 1'b1;
          stall_pct = 0;
        end
        2: begin
          idle_gaps = 1'b0;
          stall_pct = 50;
        end
        default: begin
          idle_gaps = 1'b1;
          stall_pct = $urandom_range(20, 75);
        end
      endcase

      eff_len     = (len >= 1 && len <= MAX_PATTERN) ? int'(len) : 0;
      phase_start = sent_bytes;
      phase_goal  = $urandom_range(80, 220);
      while (sent_bytes - phase_start < phase_goal) begin
        // mostly images holding the signature, some short, some pure noise
        if ($urandom_range(0, 7) == 0)
          img_len = $urandom_range(1, (eff_len > 1) ? eff_len : 2);
        else
          img_len = ((eff_len != 0) ? eff_len : 8) + $urandom_range(0, 24);
        img = {};
        for (int i = 0; i < img_len; i++) img = {img, pick_byte()};
        if (eff_len != 0 && img_len >= eff_len && $urandom_range(0, 4) != 0) begin
          repeat ($urandom_range(1, 3)) begin
            pos = $urandom_range(0, img_len - eff_len);
            for (int j = 0; j < eff_len; j++)
              if (care[j]) img[pos + j] = sig[8*j +: 8];
            // near miss: one byte of the copy flipped
            if ($urandom_range(0, 3) == 0)
              img[pos + $urandom_range(0, eff_len - 1)] ^= 8'h01;
          end
        end
        send_image(img);
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
